// File: rtl/core/lidar_intensity_correction_core_defines.svh
// Assertion macros for the intensity correction core.
`ifndef LIDAR_INTENSITY_CORRECTION_CORE_DEFINES_SVH
`define LIDAR_INTENSITY_CORRECTION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define LIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define LIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LIC_ASSERT(lbl, prop, msg)
`define LIC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/lic_pkg.sv
`default_nettype none
package lic_pkg;

  localparam int RAW_W   = 16;
  localparam int DIST_W  = 16;
  localparam int COS_W   = 16;
  localparam int COEF_W  = 32;
  localparam int MODEL_W = 32;
  localparam int CORR_W  = 16;

  localparam int ANGLE_COEFS = 4;
  localparam int RANGE_COEFS = 10;

  // Horner accumulators: range in Q.15 on 64 bits, angle below 2^35 in magnitude.
  localparam int RACC_W  = 64;
  localparam int RPROD_W = RACC_W + DIST_W + 1;
  localparam int AACC_W  = 36;
  localparam int AMAG_W  = AACC_W - 1;
  localparam int APROD_W = AACC_W + COS_W + 1;

  localparam logic signed [RPROD_W-1:0] RANGE_RND = RPROD_W'(65535);
  localparam logic signed [APROD_W-1:0] ANGLE_RND = APROD_W'(32767);

  // Model magnitude, saturated at 2^62.
  localparam int MAG_W = 63;
  localparam logic [MAG_W-1:0] MODEL_SAT = {1'b1, {(MAG_W-1){1'b0}}};

  // (0.755*2048)^2 in Q.16.
  localparam int M2Q_W = 38;
  localparam logic [M2Q_W-1:0] M2Q = 38'd156687278906;
  localparam int NUM_W = RAW_W + M2Q_W;

  localparam int QBITS = 17;
  localparam int DIV_W = MAG_W + QBITS;
  localparam logic [CORR_W-1:0] CORR_FULL = 16'd32768;

  localparam logic signed [RACC_W-1:0] RANGE_COEF [RANGE_COEFS] = '{
    64'sd71682322,
    -64'sd1390705504,
    64'sd34822931436,
    -64'sd398602937133,
    64'sd2468697184028,
    -64'sd9042123378447,
    64'sd20220579627966,
    -64'sd27160678999678,
    64'sd20151091770892,
    -64'sd6350746671021
  };

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_ANGLE_C0 = 2'd0;
  localparam logic [1:0] REG_ANGLE_C1 = 2'd1;
  localparam logic [1:0] REG_ANGLE_C2 = 2'd2;
  localparam logic [1:0] REG_ANGLE_C3 = 2'd3;

  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [DIST_W-1:0] rng;
    logic [COS_W-1:0]  cos;
  } side_t;

  // Result of the model multiplier as handed to the divider.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             raw_zero;
  } model_t;

endpackage
`default_nettype wire

// File: rtl/core/lic_channels.sv
`default_nettype none
interface lic_in_if;
  logic                       valid;
  logic                       ready;
  logic [lic_pkg::RAW_W-1:0]  raw_intensity;
  logic [lic_pkg::DIST_W-1:0] range_dist;
  logic [lic_pkg::COS_W-1:0]  cos_incidence;

  modport source (output valid, raw_intensity, range_dist, cos_incidence, input ready);
  modport sink   (input valid, raw_intensity, range_dist, cos_incidence, output ready);
endinterface

interface lic_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lic_pkg::MODEL_W-1:0] model_intensity;
  logic [lic_pkg::CORR_W-1:0]         corrected_intensity;

  modport source (output valid, model_intensity, corrected_intensity, input ready);
  modport sink   (input valid, model_intensity, corrected_intensity, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lic_range_poly.sv
`default_nettype none
module lic_range_poly #(
  parameter int DEG = 9
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_vld,
  input  wire lic_pkg::side_t                     in_side,
  output logic                                    out_vld,
  output lic_pkg::side_t                          out_side,
  output logic signed [lic_pkg::RACC_W-1:0]       out_acc
);
  import lic_pkg::*;

  // One Horner step per stage, highest coefficient first.
  logic [DEG-1:0]            vld_r;
  side_t                     side_r [DEG];
  logic signed [RACC_W-1:0]  acc_r  [DEG];

  for (genvar i = 0; i < DEG; i++) begin : g_stage
    logic signed [RACC_W-1:0]  acc_in;
    side_t                     side_in;
    logic                      vld_in;
    logic signed [RPROD_W-1:0] prod;
    logic signed [RPROD_W-1:0] prod_b;
    logic signed [RACC_W-1:0]  acc_nxt;

    if (i == 0) begin : g_first
      assign acc_in  = RANGE_COEF[DEG];
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign acc_in  = acc_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign prod    = acc_in * $signed({1'b0, side_in.rng});
    // Bias negative products so the shift truncates toward zero.
    assign prod_b  = prod + (prod[RPROD_W-1] ? RANGE_RND : '0);
    assign acc_nxt = $signed(prod_b[RACC_W+15:16]) + RANGE_COEF[DEG-1-i];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i]  <= acc_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[DEG-1];
  assign out_side = side_r[DEG-1];
  assign out_acc  = acc_r[DEG-1];
endmodule
`default_nettype wire

// File: rtl/core/lic_angle_poly.sv
`default_nettype none
module lic_angle_poly #(
  parameter int DEG = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic signed [lic_pkg::COEF_W-1:0]  coef [lic_pkg::ANGLE_COEFS],
  input  wire logic                               in_vld,
  input  wire logic [lic_pkg::RAW_W-1:0]          in_raw,
  input  wire logic [lic_pkg::COS_W-1:0]          in_cos,
  input  wire logic signed [lic_pkg::RACC_W-1:0]  in_racc,
  output logic                                    out_vld,
  output logic [lic_pkg::RAW_W-1:0]               out_raw,
  output logic signed [lic_pkg::RACC_W-1:0]       out_racc,
  output logic signed [lic_pkg::AACC_W-1:0]       out_aacc
);
  import lic_pkg::*;

  logic [DEG-1:0]            vld_r;
  logic [RAW_W-1:0]          raw_r  [DEG];
  logic [COS_W-1:0]          cos_r  [DEG];
  logic signed [RACC_W-1:0]  racc_r [DEG];
  logic signed [AACC_W-1:0]  acc_r  [DEG];

  for (genvar i = 0; i < DEG; i++) begin : g_stage
    logic signed [AACC_W-1:0]  acc_in;
    logic [RAW_W-1:0]          raw_in;
    logic [COS_W-1:0]          cos_in;
    logic signed [RACC_W-1:0]  racc_in;
    logic                      vld_in;
    logic signed [APROD_W-1:0] prod;
    logic signed [APROD_W-1:0] prod_b;
    logic signed [AACC_W-1:0]  acc_nxt;

    if (i == 0) begin : g_first
      assign acc_in  = AACC_W'(coef[DEG]);
      assign raw_in  = in_raw;
      assign cos_in  = in_cos;
      assign racc_in = in_racc;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign acc_in  = acc_r[i-1];
      assign raw_in  = raw_r[i-1];
      assign cos_in  = cos_r[i-1];
      assign racc_in = racc_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    assign prod    = acc_in * $signed({1'b0, cos_in});
    assign prod_b  = prod + (prod[APROD_W-1] ? ANGLE_RND : '0);
    assign acc_nxt = $signed(prod_b[AACC_W+14:15]) + AACC_W'(coef[DEG-1-i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i]  <= acc_nxt;
        raw_r[i]  <= raw_in;
        cos_r[i]  <= cos_in;
        racc_r[i] <= racc_in;
      end
    end
  end

  assign out_vld  = vld_r[DEG-1];
  assign out_raw  = raw_r[DEG-1];
  assign out_racc = racc_r[DEG-1];
  assign out_aacc = acc_r[DEG-1];
endmodule
`default_nettype wire

// File: rtl/core/lic_model_mul.sv
`default_nettype none
module lic_model_mul (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_vld,
  input  wire logic [lic_pkg::RAW_W-1:0]          in_raw,
  input  wire logic signed [lic_pkg::RACC_W-1:0]  in_racc,
  input  wire logic signed [lic_pkg::AACC_W-1:0]  in_aacc,
  output logic                                    out_vld,
  output lic_pkg::model_t                         out_model
);
  import lic_pkg::*;

  localparam int PP_W   = 32 + AMAG_W;
  localparam int FULL_W = PP_W + 33;

  // Stage 1: magnitudes and sign.
  logic [2:0]          vld_r;
  logic [RACC_W-1:0]   ur_r;
  logic [AMAG_W-1:0]   ua_r;
  logic [1:0]          neg_r;
  logic [RAW_W-1:0]    raw_r;
  logic [RACC_W-1:0]   ur_nxt;
  logic [AACC_W-1:0]   ua_full;

  assign ur_nxt  = in_racc[RACC_W-1] ? RACC_W'(-in_racc) : RACC_W'(in_racc);
  assign ua_full = in_aacc[AACC_W-1] ? AACC_W'(-in_aacc) : AACC_W'(in_aacc);

  // Stage 2: two partial products of the magnitude, and the numerator.
  logic [PP_W-1:0]   phi_r;
  logic [PP_W-1:0]   plo_r;
  logic [NUM_W-1:0]  num_r;
  logic              rz2_r;

  // Stage 3: recombine, drop 15 fraction bits and saturate.
  logic [FULL_W-1:0] full;
  logic [FULL_W-16:0] quo;
  logic [MAG_W-1:0]  mag_nxt;
  model_t            model_r;

  assign full    = {1'b0, phi_r, 32'b0} + {33'b0, plo_r};
  assign quo     = full[FULL_W-1:15];
  assign mag_nxt = (quo > (FULL_W-15)'(MODEL_SAT)) ? MODEL_SAT : quo[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ur_r     <= ur_nxt;
      ua_r     <= ua_full[AMAG_W-1:0];
      neg_r[0] <= in_racc[RACC_W-1] ^ in_aacc[AACC_W-1];
      raw_r    <= in_raw;

      phi_r    <= ur_r[RACC_W-1:32] * ua_r;
      plo_r    <= ur_r[31:0] * ua_r;
      num_r    <= raw_r * M2Q;
      rz2_r    <= (raw_r == '0);
      neg_r[1] <= neg_r[0];

      model_r.num      <= num_r;
      model_r.mag      <= mag_nxt;
      model_r.neg      <= neg_r[1];
      model_r.raw_zero <= rz2_r;
    end
  end

  assign out_vld   = vld_r[2];
  assign out_model = model_r;
endmodule
`default_nettype wire

// File: rtl/core/lic_divider.sv
`default_nettype none
module lic_divider (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_vld,
  input  wire lic_pkg::model_t                    in_model,
  output logic                                    out_vld,
  output logic signed [lic_pkg::MODEL_W-1:0]      out_model_int,
  output logic [lic_pkg::CORR_W-1:0]              out_corr
);
  import lic_pkg::*;

  localparam int M11_W = MAG_W - 11;
  localparam logic [M11_W-1:0] POS_MAX = M11_W'(32'h7FFF_FFFF);
  localparam logic [M11_W-1:0] NEG_MAX = M11_W'(33'h0_8000_0000);

  // Front stage: model output, special cases and quotient overflow.
  logic [M11_W-1:0]          m11;
  logic signed [MODEL_W-1:0] mi_nxt;
  logic                      ovf;
  logic                      force_nxt;
  logic [CORR_W-1:0]         fval_nxt;

  assign m11 = in_model.mag[MAG_W-1:11];
  assign ovf = {{(DIV_W-NUM_W){1'b0}}, in_model.num} >= {in_model.mag, {QBITS{1'b0}}};

  always_comb begin
    if (in_model.neg) begin
      mi_nxt = (m11 > NEG_MAX) ? $signed(32'h8000_0000) : -$signed(m11[MODEL_W-1:0]);
    end else begin
      mi_nxt = (m11 > POS_MAX) ? $signed(32'h7FFF_FFFF) : $signed(m11[MODEL_W-1:0]);
    end
    force_nxt = 1'b1;
    fval_nxt  = '0;
    if (in_model.raw_zero) begin
      fval_nxt = '0;
    end else if (in_model.mag == '0) begin
      fval_nxt = CORR_FULL;
    end else if (in_model.neg) begin
      fval_nxt = '0;
    end else if (ovf) begin
      fval_nxt = CORR_FULL;
    end else begin
      force_nxt = 1'b0;
    end
  end

  // Stage 0 is the front stage, stages 1..QBITS each settle one quotient bit.
  logic [QBITS:0]            vld_r;
  logic [NUM_W-1:0]          rem_r   [QBITS+1];
  logic [MAG_W-1:0]          mag_r   [QBITS+1];
  logic [QBITS-1:0]          q_r     [QBITS+1];
  logic signed [MODEL_W-1:0] mi_r    [QBITS+1];
  logic [QBITS:0]            force_r;
  logic [CORR_W-1:0]         fval_r  [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= in_model.num;
      mag_r[0]   <= in_model.mag;
      q_r[0]     <= '0;
      mi_r[0]    <= mi_nxt;
      force_r[0] <= force_nxt;
      fval_r[0]  <= fval_nxt;
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_bit
    logic [DIV_W-1:0] dvs;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;

    assign dvs     = {{QBITS{1'b0}}, mag_r[j-1]} << (QBITS - j);
    assign ge      = {{(DIV_W-NUM_W){1'b0}}, rem_r[j-1]} >= dvs;
    assign rem_nxt = ge ? (rem_r[j-1] - dvs[NUM_W-1:0]) : rem_r[j-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]   <= rem_nxt;
        mag_r[j]   <= mag_r[j-1];
        q_r[j]     <= {q_r[j-1][QBITS-2:0], ge};
        mi_r[j]    <= mi_r[j-1];
        force_r[j] <= force_r[j-1];
        fval_r[j]  <= fval_r[j-1];
      end
    end
  end

  // Output register: clamp and pick the special value.
  logic                      out_vld_r;
  logic signed [MODEL_W-1:0] out_mi_r;
  logic [CORR_W-1:0]         out_corr_r;
  logic [CORR_W-1:0]         corr_nxt;

  assign corr_nxt = force_r[QBITS] ? fval_r[QBITS] :
                    (q_r[QBITS] > QBITS'(CORR_FULL)) ? CORR_FULL :
                    q_r[QBITS][CORR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mi_r   <= mi_r[QBITS];
      out_corr_r <= corr_nxt;
    end
  end

  assign out_vld       = out_vld_r;
  assign out_model_int = out_mi_r;
  assign out_corr      = out_corr_r;
endmodule
`default_nettype wire

// File: rtl/core/lidar_intensity_correction_core.sv
// Lidar intensity correction core.
// Each transaction on in_chan carries one point: return intensity, range and
// cosine of incidence. For every point one transaction leaves on out_chan with
// the model intensity (range polynomial times angle cubic, Q16.16) and the
// corrected intensity, clamped to 0..1.0 in Q1.15.
// The angle cubic coefficients are written over the APB port at byte
// addresses 0, 4, 8 and 12; they should only change while no point is in
// flight.
// The pipeline has one stage per Horner step of each polynomial, three for
// the model multiplier, one front stage and seventeen one-bit stages for the
// restoring divider, and the output register. One point is accepted every
// cycle while out_chan is not holding a result back.
// When the receiver holds out_chan.ready low with a result waiting, the whole
// pipeline freezes and in_chan.ready drops, so nothing is lost or repeated.
// Reset is synchronous and active low: it empties the pipeline and clears the
// coefficient registers to zero.
`default_nettype none
`include "lidar_intensity_correction_core_defines.svh"
module lidar_intensity_correction_core #(
  parameter int RANGE_DEGREE = 9,
  parameter int ANGLE_DEGREE = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lic_in_if.sink                                 in_chan,
  lic_out_if.source                              out_chan,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lic_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import lic_pkg::*;

  // Configuration registers, one word each.
  logic signed [COEF_W-1:0] coef_r [ANGLE_COEFS];
  logic [1:0]               reg_idx;
  logic                     cfg_wr;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= '0;
      coef_r[2] <= '0;
      coef_r[3] <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ANGLE_C0: coef_r[0] <= $signed(pwdata);
        REG_ANGLE_C1: coef_r[1] <= $signed(pwdata);
        REG_ANGLE_C2: coef_r[2] <= $signed(pwdata);
        REG_ANGLE_C3: coef_r[3] <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGLE_C0: prdata = coef_r[0];
      REG_ANGLE_C1: prdata = coef_r[1];
      REG_ANGLE_C2: prdata = coef_r[2];
      REG_ANGLE_C3: prdata = coef_r[3];
      default:      prdata = '0;
    endcase
  end

  // The whole pipeline moves together unless a finished result is being held.
  logic en;
  assign en            = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  side_t in_side;
  assign in_side.raw = in_chan.raw_intensity;
  assign in_side.rng = in_chan.range_dist;
  assign in_side.cos = in_chan.cos_incidence;

  logic                     r_vld;
  side_t                    r_side;
  logic signed [RACC_W-1:0] r_acc;

  lic_range_poly #(.DEG(RANGE_DEGREE)) u_range (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_chan.valid),
    .in_side  (in_side),
    .out_vld  (r_vld),
    .out_side (r_side),
    .out_acc  (r_acc)
  );

  logic                     a_vld;
  logic [RAW_W-1:0]         a_raw;
  logic signed [RACC_W-1:0] a_racc;
  logic signed [AACC_W-1:0] a_aacc;

  lic_angle_poly #(.DEG(ANGLE_DEGREE)) u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .coef     (coef_r),
    .in_vld   (r_vld),
    .in_raw   (r_side.raw),
    .in_cos   (r_side.cos),
    .in_racc  (r_acc),
    .out_vld  (a_vld),
    .out_raw  (a_raw),
    .out_racc (a_racc),
    .out_aacc (a_aacc)
  );

  logic   m_vld;
  model_t m_model;

  lic_model_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (a_vld),
    .in_raw    (a_raw),
    .in_racc   (a_racc),
    .in_aacc   (a_aacc),
    .out_vld   (m_vld),
    .out_model (m_model)
  );

  lic_divider u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (m_vld),
    .in_model      (m_model),
    .out_vld       (out_chan.valid),
    .out_model_int (out_chan.model_intensity),
    .out_corr      (out_chan.corrected_intensity)
  );

  logic corr_ok;
  logic neg_ok;
  assign corr_ok = out_chan.corrected_intensity <= CORR_FULL;
  assign neg_ok  = (out_chan.model_intensity >= 0) || (out_chan.corrected_intensity == '0);

  // The corrected intensity never exceeds full scale.
  `LIC_ASSERT(a_corr_range, out_chan.valid |-> corr_ok, "corrected intensity above full scale")
  // A negative model always gives a zero correction.
  `LIC_ASSERT(a_neg_model, out_chan.valid |-> neg_ok, "negative model with nonzero correction")
  // Reset empties the pipeline.
  `LIC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_chan.valid, "result valid after reset")

endmodule
`default_nettype wire
